/* hdl/rsss_pkg.sv */
package rsss_pkg;

	localparam int NAME_HEAD_W = 64;
	localparam int NAME_TAIL_W = 8;
	localparam int ID_W        = 20;
	localparam int SCORE_W     = 7;
	localparam int SUM_W       = 9;
	localparam int AVG_W       = 10;
	localparam int RANK_W      = 4;
	localparam int EMIT_W      = 5;
	localparam int EMIT_LIMIT  = 16;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

	// avg = (10*sum + 1) / 3 via multiply by 2731 >> 13 (exact below 8192)
	localparam int AVG_NUM_W  = 12;
	localparam int AVG_RECIP  = 2731;
	localparam int AVG_SHIFT  = 13;
	localparam int AVG_PROD_W = 24;

	typedef struct packed {
		logic [NAME_HEAD_W-1:0] name_head;
		logic [NAME_TAIL_W-1:0] name_tail;
		logic [ID_W-1:0]        student_id;
		logic [SCORE_W-1:0]     math;
		logic [SCORE_W-1:0]     physics;
		logic [SCORE_W-1:0]     english;
		logic [SUM_W-1:0]       sum;
	} rec_t;

	typedef struct packed {
		rec_t rec;
		logic last;
	} q_item_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} back_state_t;

	function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] s);
		logic [SCORE_W-1:0] r;
		r = (s > SCORE_MAX) ? SCORE_MAX : s;
		return r;
	endfunction

endpackage

/* hdl/rsss_front.sv */
module rsss_front
	import rsss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [NAME_HEAD_W-1:0] name_head,
	input  logic [NAME_TAIL_W-1:0] name_tail,
	input  logic [ID_W-1:0]        student_id,
	input  logic [SCORE_W-1:0]     math_score,
	input  logic [SCORE_W-1:0]     physics_score,
	input  logic [SCORE_W-1:0]     english_score,
	input  logic                   last,
	output logic                   q_valid,
	output q_item_t                q_item,
	input  logic                   q_pop
);

	q_item_t     mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;
	q_item_t     new_item;
	logic        push;
	logic [SCORE_W-1:0] m_c, p_c, e_c;

	// clamp scores and form the sort key
	always_comb begin
		m_c = clamp_score(math_score);
		p_c = clamp_score(physics_score);
		e_c = clamp_score(english_score);
		new_item.rec.name_head  = name_head;
		new_item.rec.name_tail  = name_tail;
		new_item.rec.student_id = student_id;
		new_item.rec.math       = m_c;
		new_item.rec.physics    = p_c;
		new_item.rec.english    = e_c;
		new_item.rec.sum        = SUM_W'(m_c) + SUM_W'(p_c) + SUM_W'(e_c);
		new_item.last           = last;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/rsss_back.sv */
module rsss_back
	import rsss_pkg::*;
#(
	parameter int MAX_RECORDS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  q_item_t                q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NAME_HEAD_W-1:0] out_name_head,
	output logic [NAME_TAIL_W-1:0] out_name_tail,
	output logic [ID_W-1:0]        out_student_id,
	output logic [SCORE_W-1:0]     out_math,
	output logic [SCORE_W-1:0]     out_physics,
	output logic [SCORE_W-1:0]     out_english,
	output logic [SUM_W-1:0]       score_sum,
	output logic [AVG_W-1:0]       average_tenths,
	output logic [RANK_W-1:0]      rank_position,
	output logic                   out_last
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	back_state_t      state_q, state_nxt;
	rec_t             cell_q [MAX_RECORDS];
	logic [MAX_RECORDS-1:0] ge;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_new;
	logic [EMIT_W-1:0] emit_n_q;
	logic [EMIT_W-1:0] emit_n;
	logic [RANK_W-1:0] rank_q;
	logic             ins_en;
	logic             emit_step;
	logic             emit_last;
	logic             out_valid_q;
	rec_t             out_rec_q;
	logic [AVG_W-1:0] avg_q;
	logic [RANK_W-1:0] out_rank_q;
	logic             out_last_q;
	logic [AVG_NUM_W-1:0]  avg_num;
	logic [AVG_PROD_W-1:0] avg_prod;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (q_valid && q_item.last) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_step && emit_last) state_nxt = ST_LOAD;
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		emit_step = 1'b0;
		case (state_q)
			ST_LOAD: q_pop     = q_valid;
			ST_EMIT: emit_step = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign ins_en    = q_pop && (count_q < CNT_W'(MAX_RECORDS));
	assign count_new = ins_en ? count_q + CNT_W'(1) : count_q;
	assign emit_n    = (int'(count_new) > EMIT_LIMIT) ? EMIT_W'(EMIT_LIMIT) : EMIT_W'(count_new);
	assign emit_last = ({1'b0, rank_q} + EMIT_W'(1)) == emit_n_q;

	// insertion sort row: cells hold stored records in descending sum order
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		assign ge[i] = (CNT_W'(i) < count_q) && (cell_q[i].sum >= q_item.rec.sum);

		always_ff @(posedge clk) begin
			if (ins_en && !ge[i]) begin
				if (i == 0) begin
					cell_q[i] <= q_item.rec;
				end else if (ge[(i > 0) ? i - 1 : 0]) begin
					cell_q[i] <= q_item.rec;
				end else begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end
			end else if (emit_step && (i < MAX_RECORDS - 1)) begin
				cell_q[i] <= cell_q[(i < MAX_RECORDS - 1) ? i + 1 : i];
			end
		end
	end

	always_comb begin
		avg_num  = (AVG_NUM_W'(cell_q[0].sum) << 3) + (AVG_NUM_W'(cell_q[0].sum) << 1)
		           + AVG_NUM_W'(1);
		avg_prod = AVG_PROD_W'(avg_num) * AVG_PROD_W'(AVG_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			emit_n_q    <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (q_pop) begin
				if (q_item.last) begin
					emit_n_q <= emit_n;
					rank_q   <= '0;
				end
				count_q <= count_new;
			end
			if (emit_step) begin
				rank_q      <= rank_q + RANK_W'(1);
				out_valid_q <= 1'b1;
				if (emit_last) begin
					count_q <= '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_rec_q  <= cell_q[0];
			avg_q      <= avg_prod[AVG_SHIFT +: AVG_W];
			out_rank_q <= rank_q;
			out_last_q <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_name_head  = out_rec_q.name_head;
	assign out_name_tail  = out_rec_q.name_tail;
	assign out_student_id = out_rec_q.student_id;
	assign out_math       = out_rec_q.math;
	assign out_physics    = out_rec_q.physics;
	assign out_english    = out_rec_q.english;
	assign score_sum      = out_rec_q.sum;
	assign average_tenths = avg_q;
	assign rank_position  = out_rank_q;
	assign out_last       = out_last_q;

endmodule

/* hdl/record_sort_by_score_sum.sv */
// Record ranking by score sum.
// Input channel (in_valid/in_stall): one student record per request; a request
// with last set closes the set. Records beyond MAX_RECORDS are dropped, but their
// last flag still closes the set.
// Output channel (out_valid/out_stall): the stored records in descending order of
// score sum, equal sums in load order, each with sum, average in tenths and rank;
// out_last marks the final one. At most 16 are emitted per set.
// Throughput: records load one per cycle while in_stall is low, through a
// two-entry queue into a row of insertion-sort cells, so the set is already
// ordered when last arrives. After the last request is taken it passes the queue
// and the sort cells before the output register presents the first result (later
// if the previous set is still being emitted), then one result per cycle while
// out_stall is low. While results are being emitted the queue fills and in_stall
// rises after two further requests. A stalled result is held in the output
// register and emission pauses. Reset clears the queue, record count, state and
// output valid; stored records are not cleared.
module record_sort_by_score_sum
	import rsss_pkg::*;
#(
	parameter int MAX_RECORDS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [NAME_HEAD_W-1:0] name_head,
	input  logic [NAME_TAIL_W-1:0] name_tail,
	input  logic [ID_W-1:0]        student_id,
	input  logic [SCORE_W-1:0]     math_score,
	input  logic [SCORE_W-1:0]     physics_score,
	input  logic [SCORE_W-1:0]     english_score,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NAME_HEAD_W-1:0] out_name_head,
	output logic [NAME_TAIL_W-1:0] out_name_tail,
	output logic [ID_W-1:0]        out_student_id,
	output logic [SCORE_W-1:0]     out_math,
	output logic [SCORE_W-1:0]     out_physics,
	output logic [SCORE_W-1:0]     out_english,
	output logic [SUM_W-1:0]       score_sum,
	output logic [AVG_W-1:0]       average_tenths,
	output logic [RANK_W-1:0]      rank_position,
	output logic                   out_last
);

	logic    q_valid;
	q_item_t q_item;
	logic    q_pop;

	rsss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.name_head     (name_head),
		.name_tail     (name_tail),
		.student_id    (student_id),
		.math_score    (math_score),
		.physics_score (physics_score),
		.english_score (english_score),
		.last          (last),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	rsss_back #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_name_head  (out_name_head),
		.out_name_tail  (out_name_tail),
		.out_student_id (out_student_id),
		.out_math       (out_math),
		.out_physics    (out_physics),
		.out_english    (out_english),
		.score_sum      (score_sum),
		.average_tenths (average_tenths),
		.rank_position  (rank_position),
		.out_last       (out_last)
	);

endmodule
